@@ hw/rtl/assert_macros.svh @@
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising edge outside reset.
`define ASSERT_IMPLY(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("assertion failed");

// Next-cycle implication checked on every rising edge outside reset.
`define ASSERT_NEXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("assertion failed");

`endif

@@ hw/rtl/srrip_pkg.sv @@
`default_nettype none
package srrip_pkg;
    localparam int NUM_SETS          = 2048;
    localparam int NUM_WAYS          = 16;
    localparam int RRPV_WIDTH        = 2;
    localparam int COUNTER_WIDTH     = 3;
    localparam int PREDICTOR_ENTRIES = 8192;
    localparam int SET_W  = $clog2(NUM_SETS);
    localparam int WAY_W  = $clog2(NUM_WAYS);
    localparam int PRED_W = $clog2(PREDICTOR_ENTRIES);
    localparam int SIG_W  = 13;
    localparam int SET_IN_W = 11;
    localparam int WAY_IN_W = 4;
    localparam int LINE_W = RRPV_WIDTH + 1 + SIG_W;
    localparam int ROW_W  = NUM_WAYS * LINE_W;
    localparam logic [RRPV_WIDTH-1:0] RRPV_TOP = '1;
    localparam logic [COUNTER_WIDTH-1:0] CTR_TOP = '1;
    localparam logic [COUNTER_WIDTH-1:0] CTR_MID = CTR_TOP >> 1;
    localparam logic [2:0] THRESH_RESET = 3'd3;

    typedef enum logic [2:0] {
        ST_CLEAR, ST_IDLE, ST_READ, ST_PRED, ST_WRITE, ST_OUT
    } t_state;

    typedef struct packed {
        logic [RRPV_WIDTH-1:0] rrpv;
        logic                  reused;
        logic [SIG_W-1:0]      sig;
    } t_line;
endpackage
`default_nettype wire

@@ hw/rtl/srrip_ram.sv @@
`default_nettype none
module srrip_ram #(
    parameter int DEPTH = 2048,
    parameter int WIDTH = 8
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

@@ hw/rtl/srrip_age.sv @@
`default_nettype none
module srrip_age (
    input  wire logic [srrip_pkg::ROW_W-1:0] i_row,
    output logic      [srrip_pkg::ROW_W-1:0] o_row,
    output logic      [srrip_pkg::WAY_W-1:0] o_victim
);
    import srrip_pkg::*;
    t_line                 v_ln;
    t_line                 v_out;
    logic [RRPV_WIDTH-1:0] v_top;
    logic [RRPV_WIDTH-1:0] v_lift;
    logic                  v_found;

    always_comb begin
        v_top = '0;
        for (int w = 0; w < NUM_WAYS; w++) begin
            v_ln = i_row[w*LINE_W +: LINE_W];
            if (v_ln.rrpv > v_top) begin
                v_top = v_ln.rrpv;
            end
        end
        v_lift   = RRPV_TOP - v_top;
        o_victim = '0;
        v_found  = 1'b0;
        o_row    = i_row;
        for (int w = 0; w < NUM_WAYS; w++) begin
            v_out      = i_row[w*LINE_W +: LINE_W];
            v_out.rrpv = v_out.rrpv + v_lift;
            o_row[w*LINE_W +: LINE_W] = v_out;
            if (!v_found && v_out.rrpv == RRPV_TOP) begin
                v_found  = 1'b1;
                o_victim = WAY_W'(w);
            end
        end
    end
endmodule
`default_nettype wire

@@ hw/rtl/ship_rrip_replacement_unit.sv @@
// Channel | Direction | Signals
// in      | input     | i_valid, o_ready, mode/set/way/signature/hit
// out     | output    | o_valid, i_ready, o_victim_way
// cfg     | input     | i_cfg_valid, o_cfg_ready, i_cfg_data
// A victim request reads the set row, ages it and writes it back, then loads the
// chosen way into the result register. A hit update reads the row and writes it
// back; a miss update reads the row, reads the old counter, reads the new counter
// while writing the trained one, and writes the row.
// The single read port of each memory is why these steps are taken in turn.
// After reset a clearing pass writes every predictor entry and every set row,
// while no input transfer is taken. A result waits in its register until
// transferred; the next input is taken meanwhile, and a new victim waits until
// the register is free.
`default_nettype none
module ship_rrip_replacement_unit (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_valid,
    output logic                                o_ready,
    input  wire logic                           i_mode,
    input  wire logic [srrip_pkg::SET_IN_W-1:0] i_set_index,
    input  wire logic [srrip_pkg::WAY_IN_W-1:0] i_way_index,
    input  wire logic [srrip_pkg::SIG_W-1:0]    i_pc_signature,
    input  wire logic                           i_was_hit,
    output logic                                o_valid,
    input  wire logic                           i_ready,
    output logic      [srrip_pkg::WAY_IN_W-1:0] o_victim_way,
    input  wire logic                           i_cfg_valid,
    output logic                                o_cfg_ready,
    input  wire logic [2:0]                     i_cfg_data
);
    import srrip_pkg::*;

    localparam int CLR_N = (NUM_SETS > PREDICTOR_ENTRIES) ? NUM_SETS : PREDICTOR_ENTRIES;
    localparam int CLR_W = $clog2(CLR_N + 1);

    t_state r_state, n_state;
    logic [CLR_W-1:0] r_clr;
    logic [2:0]       r_thresh;
    logic [SET_W-1:0] r_set;
    logic [WAY_IN_W-1:0] r_way;
    logic [SIG_W-1:0] r_pc;
    logic             r_mode, r_hit;
    logic [ROW_W-1:0] r_row;
    logic             r_ovalid;
    logic [WAY_IN_W-1:0] r_victim;
    logic [WAY_IN_W-1:0] r_found;
    logic [COUNTER_WIDTH-1:0] r_old_ctr;
    logic             r_sub;
    logic             out_load;

    // Memories.
    logic             row_we;
    logic [SET_W-1:0] row_waddr, row_raddr;
    logic [ROW_W-1:0] row_wdata, row_rdata;
    logic             pr_we;
    logic [PRED_W-1:0] pr_waddr, pr_raddr;
    logic [COUNTER_WIDTH-1:0] pr_wdata, pr_rdata;

    // The row read is issued at the accepting edge, so the set comes straight
    // from the input port while idle.
    assign row_raddr = (r_state == ST_IDLE) ? i_set_index[SET_W-1:0] : r_set;

    srrip_ram #(.DEPTH(NUM_SETS), .WIDTH(ROW_W)) u_rows (
        .i_clk(i_clk), .i_we(row_we), .i_waddr(row_waddr), .i_wdata(row_wdata),
        .i_raddr(row_raddr), .o_rdata(row_rdata));

    srrip_ram #(.DEPTH(PREDICTOR_ENTRIES), .WIDTH(COUNTER_WIDTH)) u_pred (
        .i_clk(i_clk), .i_we(pr_we), .i_waddr(pr_waddr), .i_wdata(pr_wdata),
        .i_raddr(pr_raddr), .o_rdata(pr_rdata));

    logic [ROW_W-1:0] aged_row;
    logic [WAY_W-1:0] aged_victim;
    srrip_age u_age (.i_row(row_rdata), .o_row(aged_row), .o_victim(aged_victim));

    // Line addressed by an update; the row register holds the set once read.
    t_line cur_line, new_line, init_line, rd_line;
    logic  way_ok;
    logic [WAY_W-1:0] way_sel;
    logic [COUNTER_WIDTH-1:0] trained;
    logic [COUNTER_WIDTH-1:0] new_ctr;
    logic [ROW_W-1:0] init_row;

    always_comb begin
        way_ok   = ({1'b0, r_way} < (WAY_IN_W+1)'(NUM_WAYS));
        way_sel  = r_way[WAY_W-1:0];
        cur_line = r_row[way_sel*LINE_W +: LINE_W];
        rd_line  = row_rdata[way_sel*LINE_W +: LINE_W];
        init_line.rrpv   = RRPV_TOP;
        init_line.reused = 1'b0;
        init_line.sig    = '0;
        init_row = {NUM_WAYS{init_line}};
        // Old counter trained up on reuse, down otherwise, saturating.
        if (cur_line.reused) begin
            trained = (r_old_ctr == CTR_TOP) ? r_old_ctr : r_old_ctr + 1'b1;
        end else begin
            trained = (r_old_ctr == '0) ? r_old_ctr : r_old_ctr - 1'b1;
        end
        // The counter memory reads before it writes, so when the old and new
        // signatures share an entry the trained value is taken directly.
        new_ctr = (cur_line.sig[PRED_W-1:0] == r_pc[PRED_W-1:0]) ? trained : pr_rdata;
        new_line = cur_line;
        if (r_hit) begin
            new_line.rrpv   = '0;
            new_line.reused = 1'b1;
        end else begin
            new_line.sig    = r_pc;
            new_line.reused = 1'b0;
            if ({3'b0, new_ctr} > {{COUNTER_WIDTH{1'b0}}, r_thresh}) begin
                new_line.rrpv = '0;
            end else if (new_ctr != '0) begin
                new_line.rrpv = RRPV_TOP - 1'b1;
            end else begin
                new_line.rrpv = RRPV_TOP;
            end
        end
    end

    always_comb begin
        n_state   = r_state;
        row_we    = 1'b0;
        row_waddr = r_set;
        row_wdata = aged_row;
        pr_we     = 1'b0;
        pr_waddr  = r_clr[PRED_W-1:0];
        pr_wdata  = CTR_MID;
        pr_raddr  = r_pc[PRED_W-1:0];
        o_ready   = 1'b0;
        out_load  = 1'b0;
        case (r_state)
            ST_CLEAR: begin
                row_we    = (r_clr < CLR_W'(NUM_SETS));
                row_waddr = r_clr[SET_W-1:0];
                row_wdata = init_row;
                pr_we     = (r_clr < CLR_W'(PREDICTOR_ENTRIES));
                if (r_clr == CLR_W'(CLR_N - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                o_ready = 1'b1;
                if (i_valid && o_ready) begin
                    n_state = ST_READ;
                end
            end
            ST_READ: begin
                // Row data arrives now.
                if (!r_mode) begin
                    row_we  = 1'b1;
                    n_state = ST_OUT;
                end else if (!way_ok) begin
                    n_state = ST_IDLE;
                end else if (r_hit) begin
                    n_state = ST_WRITE;
                end else begin
                    n_state = ST_PRED;
                end
            end
            ST_PRED: begin
                // Old counter read issued last cycle is in r_old_ctr path.
                pr_raddr = r_pc[PRED_W-1:0];
                n_state  = ST_WRITE;
            end
            ST_WRITE: begin
                if (!r_hit) begin
                    pr_we    = 1'b1;
                    pr_waddr = cur_line.sig[PRED_W-1:0];
                    pr_wdata = trained;
                end
                if (r_hit || r_sub) begin
                    row_we    = 1'b1;
                    row_wdata = r_row;
                    row_wdata[way_sel*LINE_W +: LINE_W] = new_line;
                    n_state   = ST_IDLE;
                end
            end
            ST_OUT: begin
                // The victim moves to the result register once it is free.
                out_load = !r_ovalid || i_ready;
                if (out_load) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
        if (r_state == ST_READ) begin
            pr_raddr = rd_line.sig[PRED_W-1:0];
        end
        if (r_state == ST_WRITE && !r_sub) begin
            pr_raddr = r_pc[PRED_W-1:0];
        end
    end

    // On a miss the write state first writes the trained counter and rereads the new
    // signature's counter, then writes the line.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_CLEAR;
            r_clr    <= '0;
            r_thresh <= THRESH_RESET;
            r_ovalid <= 1'b0;
            r_sub    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_CLEAR) begin
                r_clr <= r_clr + 1'b1;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                r_thresh <= i_cfg_data;
            end
            if (out_load) begin
                r_ovalid <= 1'b1;
            end else if (o_valid && i_ready) begin
                r_ovalid <= 1'b0;
            end
            if (r_state == ST_WRITE && !r_hit) begin
                r_sub <= !r_sub;
            end else begin
                r_sub <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE && i_valid && o_ready) begin
            r_mode <= i_mode;
            r_set  <= i_set_index[SET_W-1:0];
            r_way  <= i_way_index;
            r_pc   <= i_pc_signature;
            r_hit  <= i_was_hit;
        end
        if (r_state == ST_READ) begin
            r_row   <= row_rdata;
            r_found <= WAY_IN_W'(aged_victim);
        end
        if (r_state == ST_PRED) begin
            r_old_ctr <= pr_rdata;
        end
        if (out_load) begin
            r_victim <= r_found;
        end
    end

    assign o_valid      = r_ovalid;
    assign o_victim_way = r_victim;
    assign o_cfg_ready  = 1'b1;
endmodule
`default_nettype wire

@@ hw/rtl/srrip_checker.sv @@
`default_nettype none
`include "assert_macros.svh"
module srrip_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       i_valid,
    input wire logic       o_ready,
    input wire logic       o_valid,
    input wire logic       i_ready,
    input wire logic       i_mode,
    input wire logic [3:0] o_victim_way
);
    // A transfer in closes the input side for the next cycle.
    `ASSERT_NEXT(a_busy_after_in, i_clk, i_rst_n, i_valid && o_ready, !o_ready)
    // An update taken with no result waiting never raises a result the next cycle.
    `ASSERT_NEXT(a_upd_quiet, i_clk, i_rst_n, i_valid && o_ready && i_mode && !o_valid, !o_valid)
    // A result holds until taken.
    `ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && !i_ready, o_valid)
    // The victim way does not change while its result waits.
    `ASSERT_NEXT(a_victim_hold, i_clk, i_rst_n, o_valid && !i_ready, $stable(o_victim_way))
endmodule

bind ship_rrip_replacement_unit srrip_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_ready(o_ready),
    .o_valid(o_valid), .i_ready(i_ready), .i_mode(i_mode),
    .o_victim_way(o_victim_way));
`default_nettype wire

@@ verif/tb_ship_rrip_replacement_unit.sv @@
`default_nettype none
module tb_ship_rrip_replacement_unit;
    import srrip_pkg::*;

    // Operation codes carried on the mode field.
    localparam logic MODE_VICTIM = 1'b0;
    localparam logic MODE_UPDATE = 1'b1;
    // Cycles without any transfer before the run is declared hung. The clearing
    // pass after reset runs without any transfer, so the limit sits well above its length.
    localparam int HANG_LIMIT = 40000;
    // Settling time after the last result; an update produces no result, so this covers
    // any update still in flight.
    localparam int SETTLE_CYCLES = 20;

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_ready;
    logic                 in_mode;
    logic [SET_IN_W-1:0]  in_set;
    logic [WAY_IN_W-1:0]  in_way;
    logic [SIG_W-1:0]     in_sig;
    logic                 in_hit;
    logic                 out_valid;
    logic                 out_ready;
    logic [WAY_IN_W-1:0]  out_victim;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [2:0]           cfg_data;

    ship_rrip_replacement_unit uut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_valid        (in_valid),
        .o_ready        (in_ready),
        .i_mode         (in_mode),
        .i_set_index    (in_set),
        .i_way_index    (in_way),
        .i_pc_signature (in_sig),
        .i_was_hit      (in_hit),
        .o_valid        (out_valid),
        .i_ready        (out_ready),
        .o_victim_way   (out_victim),
        .i_cfg_valid    (cfg_valid),
        .o_cfg_ready    (cfg_ready),
        .i_cfg_data     (cfg_data)
    );

    // Shadow copy of the replacement state, kept at the block's own widths.
    logic [RRPV_WIDTH-1:0]    shadow_rrpv   [NUM_SETS*NUM_WAYS];
    logic                     shadow_reused [NUM_SETS*NUM_WAYS];
    logic [SIG_W-1:0]         shadow_sig    [NUM_SETS*NUM_WAYS];
    logic [COUNTER_WIDTH-1:0] shadow_ctr    [PREDICTOR_ENTRIES];
    logic [2:0]               shadow_threshold;

    logic [WAY_IN_W-1:0] victim_queue[$];
    int  mismatches;
    bit  timed_out;
    bit  idle_enabled;
    int  quiet_cycles;

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Victim search: ages the whole set so that its largest value reaches the
    // top, writes the aging back and returns the first way at the top.
    function automatic logic [WAY_IN_W-1:0] choose_victim(int unsigned base);
        logic [RRPV_WIDTH-1:0] peak;
        logic [RRPV_WIDTH-1:0] lift;
        peak = '0;
        for (int w = 0; w < NUM_WAYS; w++) begin
            if (shadow_rrpv[base + w] > peak) peak = shadow_rrpv[base + w];
        end
        lift = RRPV_TOP - peak;
        for (int w = 0; w < NUM_WAYS; w++) begin
            shadow_rrpv[base + w] = shadow_rrpv[base + w] + lift;
        end
        for (int w = 0; w < NUM_WAYS; w++) begin
            if (shadow_rrpv[base + w] == RRPV_TOP) return w[WAY_IN_W-1:0];
        end
        return '0;
    endfunction

    // Hit promotes the line; a fill trains the evicted signature's counter and
    // picks the insertion position from the new signature's counter.
    function automatic void apply_access(int unsigned line, logic [SIG_W-1:0] sig,
                                         logic hit);
        logic [PRED_W-1:0]        old_entry;
        logic [PRED_W-1:0]        new_entry;
        logic [COUNTER_WIDTH-1:0] count;
        if (hit) begin
            shadow_rrpv[line]   = '0;
            shadow_reused[line] = 1'b1;
            return;
        end
        old_entry = shadow_sig[line][PRED_W-1:0];
        if (shadow_reused[line]) begin
            if (shadow_ctr[old_entry] != CTR_TOP) shadow_ctr[old_entry]++;
        end else begin
            if (shadow_ctr[old_entry] != '0) shadow_ctr[old_entry]--;
        end
        new_entry = sig[PRED_W-1:0];
        shadow_sig[line]    = sig;
        shadow_reused[line] = 1'b0;
        count = shadow_ctr[new_entry];
        if (count > shadow_threshold) shadow_rrpv[line] = '0;
        else if (count != '0)         shadow_rrpv[line] = RRPV_TOP - 1'b1;
        else                          shadow_rrpv[line] = RRPV_TOP;
    endfunction

    // Sends one request and folds it into the shadow state once accepted.
    // Valid stays high after the transfer; the next idle cycle or the caller
    // drops it, so back-to-back requests keep it high.
    task automatic send_request(logic mode, logic [SET_IN_W-1:0] set_idx,
                                logic [WAY_IN_W-1:0] way, logic [SIG_W-1:0] sig,
                                logic hit);
        int unsigned base;
        while (idle_enabled && $urandom_range(99) < 24) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_mode  <= mode;
        in_set   <= set_idx;
        in_way   <= way;
        in_sig   <= sig;
        in_hit   <= hit;
        do @(posedge clk); while (!in_ready);
        base = (int'(set_idx) % NUM_SETS) * NUM_WAYS;
        if (mode == MODE_VICTIM) victim_queue.push_back(choose_victim(base));
        else if (int'(way) < NUM_WAYS) apply_access(base + int'(way), sig, hit);
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        while (victim_queue.size() != 0 && !timed_out) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Only called with the block idle.
    task automatic write_threshold(logic [2:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        shadow_threshold = value;
    endtask

    // Random request content; a few hot sets keep aging and training deep.
    task automatic send_random(int hot_sets);
        logic [SET_IN_W-1:0] set_idx;
        set_idx = ($urandom_range(9) < 8) ? SET_IN_W'($urandom_range(hot_sets - 1))
                                           : SET_IN_W'($urandom);
        send_request(logic'($urandom_range(2) == 0), set_idx, WAY_IN_W'($urandom),
                     ($urandom_range(3) == 0) ? SIG_W'($urandom)
                                              : SIG_W'($urandom_range(15)),
                     logic'($urandom));
    endtask

    task automatic test_directed();
        // Fresh set: every way is at the top, so way 0 is the victim.
        send_request(MODE_VICTIM, '0, '0, '0, 1'b0);
        send_request(MODE_VICTIM, '1, '0, '1, 1'b1);
        // Hit on way 0 and way 15 of set 0, then aging and search.
        send_request(MODE_UPDATE, '0, '0, '0, 1'b1);
        send_request(MODE_UPDATE, '0, '1, '0, 1'b1);
        send_request(MODE_VICTIM, '0, '0, '0, 1'b0);
        // Promote every way so the next search must age the whole set.
        for (int w = 0; w < NUM_WAYS; w++) begin
            send_request(MODE_UPDATE, 11'd5, WAY_IN_W'(w), '1, 1'b1);
        end
        send_request(MODE_VICTIM, 11'd5, '0, '0, 1'b0);
        // Fills: a reused line trains up, an unused one trains down.
        send_request(MODE_UPDATE, 11'd5, 4'd3, '1, 1'b0);
        send_request(MODE_UPDATE, '1, 4'd7, 13'h1555, 1'b0);
        send_request(MODE_UPDATE, '1, 4'd7, 13'h0AAA, 1'b0);
        send_request(MODE_VICTIM, 11'd5, '1, '1, 1'b1);
        drain_results();
    endtask

    // Drives the predictor counters to both ends, up under one signature and down under
    // another, so that insertion at zero, near the top and at the top all occur.
    task automatic test_training(logic [2:0] threshold);
        write_threshold(threshold);
        for (int k = 0; k < 12; k++) begin
            send_request(MODE_UPDATE, 11'd9, 4'd2, 13'd77, 1'b1);
            send_request(MODE_UPDATE, 11'd9, 4'd2, 13'd77, 1'b0);
            send_request(MODE_VICTIM, 11'd9, '0, '0, 1'b0);
        end
        for (int k = 0; k < 12; k++) begin
            send_request(MODE_UPDATE, 11'd10, 4'd4, 13'd78, 1'b0);
            send_request(MODE_VICTIM, 11'd10, '0, '0, 1'b0);
        end
        drain_results();
    endtask

    task automatic test_random(int count, int hot_sets);
        for (int k = 0; k < count; k++) send_random(hot_sets);
        drain_results();
    endtask

    // The sender holds off until every expected result is back, then resumes.
    task automatic test_hold_off(int count);
        for (int k = 0; k < count; k++) begin
            send_random(4);
            if (k % 25 == 24) begin
                in_valid <= 1'b0;
                do @(posedge clk); while (victim_queue.size() != 0 && !timed_out);
            end
        end
        drain_results();
    endtask

    // Result checker with a randomly stalling receiver.
    always @(posedge clk) begin
        if (rst_n && out_valid && out_ready) begin
            if (victim_queue.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected victim %0d", out_victim);
            end else begin
                if (out_victim !== victim_queue[0]) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("victim mismatch: expected %0d actual %0d",
                                 victim_queue[0], out_victim);
                    end
                end
                void'(victim_queue.pop_front());
            end
        end
        out_ready <= !(idle_enabled && $urandom_range(99) < 24);
    end

    // Watchdog on cycles without any transfer.
    always @(posedge clk) begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)
            || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= HANG_LIMIT && !timed_out) begin
            timed_out = 1'b1;
            $display("ship_rrip_replacement_unit test failed");
            $finish;
        end
    end

    initial begin
        mismatches = 0;
        timed_out = 1'b0;
        quiet_cycles = 0;
        idle_enabled = 1'b1;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_mode = MODE_VICTIM;
        in_set = '0;
        in_way = '0;
        in_sig = '0;
        in_hit = 1'b0;
        out_ready = 1'b1;
        cfg_valid = 1'b0;
        cfg_data = '0;
        for (int i = 0; i < NUM_SETS*NUM_WAYS; i++) begin
            shadow_rrpv[i] = RRPV_TOP;
            shadow_reused[i] = 1'b0;
            shadow_sig[i] = '0;
        end
        for (int i = 0; i < PREDICTOR_ENTRIES; i++) shadow_ctr[i] = CTR_MID;
        shadow_threshold = THRESH_RESET;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        test_directed();
        test_training(3'd7);
        test_training(3'd0);
        test_training(3'd2);
        test_random(600, 8);
        // A long stretch with no idling on either side.
        idle_enabled = 1'b0;
        test_random(400, 16);
        idle_enabled = 1'b1;
        write_threshold(3'd5);
        test_hold_off(300);
        write_threshold(3'd1);
        test_random(400, 32);

        if (mismatches == 0 && victim_queue.size() == 0) begin
            $display("ship_rrip_replacement_unit test passed");
        end else begin
            $display("ship_rrip_replacement_unit test failed");
        end
        $finish;
    end
endmodule
`default_nettype wire

@@ sim.f @@
+incdir+hw/rtl
hw/rtl/srrip_pkg.sv
hw/rtl/srrip_ram.sv
hw/rtl/srrip_age.sv
hw/rtl/ship_rrip_replacement_unit.sv
hw/rtl/srrip_checker.sv
verif/tb_ship_rrip_replacement_unit.sv
